[src/ecli_pkg.sv]
// Shared widths, payload types and the division step of the edge clip block.
`default_nettype none
package ecli_pkg;
    localparam int CW    = 32;      // coordinate width
    localparam int DW    = CW + 1;  // difference of two coordinates
    localparam int PW    = 2 * DW;  // product of two differences
    localparam int SW    = PW + 1;  // sum of two products
    localparam int MW    = SW + 1;  // magnitudes of numerator, denominator, remainder
    localparam int QW    = DW + 1;  // quotient accumulator
    localparam int LANES = 4;       // x, y, u, v
    localparam int STEPS = DW;      // one multiplier bit per division step
    localparam int QDEPTH = 4;
    localparam int QPW   = $clog2(QDEPTH);
    localparam int IXW   = 8;       // register index width on the config port

    localparam logic [IXW-1:0] REG_CLIP_START_X = 8'd0;
    localparam logic [IXW-1:0] REG_CLIP_START_Y = 8'd1;
    localparam logic [IXW-1:0] REG_CLIP_END_X   = 8'd2;
    localparam logic [IXW-1:0] REG_CLIP_END_Y   = 8'd3;

    typedef struct packed {
        logic                           crosses;
        logic                           point_valid;
        logic [MW-1:0]                  num;
        logic [MW-1:0]                  den;
        logic [LANES-1:0][CW-1:0]       ca;
        logic [LANES-1:0][DW-1:0]       mag;
        logic [LANES-1:0]               dneg;
    } t_job;

    typedef struct packed {
        t_job                           job;
        logic [LANES-1:0][MW-1:0]       rem;
        logic [LANES-1:0][QW-1:0]       quo;
    } t_div;

    // One step of the long product-division: fold in one bit of |delta|,
    // keep rem below den and shift a digit of 0, 1 or 2 into the quotient.
    function automatic t_div div_step(t_div d, logic [5:0] bitpos);
        t_div          r;
        logic [MW:0]   t;
        logic [MW:0]   d1;
        logic [MW:0]   d2;
        logic [1:0]    dig;
        r  = d;
        d1 = {1'b0, d.job.den};
        d2 = {d.job.den, 1'b0};
        for (int l = 0; l < LANES; l++) begin
            t = {d.rem[l], 1'b0} + (d.job.mag[l][bitpos] ? {1'b0, d.job.num} : '0);
            if (t >= d2) begin
                t   = t - d2;
                dig = 2'd2;
            end else if (t >= d1) begin
                t   = t - d1;
                dig = 2'd1;
            end else begin
                dig = 2'd0;
            end
            r.rem[l] = t[MW-1:0];
            r.quo[l] = {d.quo[l][QW-2:0], 1'b0} + QW'(dig);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

[src/ecli_ifs.sv]
// Handshake interfaces for the edge, result and configuration channels.
`default_nettype none
interface ecli_seg_if;
    logic valid;
    logic ready;
    logic signed [31:0] seg_start_x, seg_start_y, seg_start_u, seg_start_v;
    logic signed [31:0] seg_end_x, seg_end_y, seg_end_u, seg_end_v;
    modport source (output valid, seg_start_x, seg_start_y, seg_start_u, seg_start_v,
                    seg_end_x, seg_end_y, seg_end_u, seg_end_v, input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_start_u, seg_start_v,
                    seg_end_x, seg_end_y, seg_end_u, seg_end_v, output ready);
endinterface

interface ecli_hit_if;
    logic valid;
    logic ready;
    logic crosses;
    logic point_valid;
    logic signed [31:0] hit_x, hit_y, hit_u, hit_v;
    modport source (output valid, crosses, point_valid, hit_x, hit_y, hit_u, hit_v,
                    input ready);
    modport sink   (input valid, crosses, point_valid, hit_x, hit_y, hit_u, hit_v,
                    output ready);
endinterface

interface ecli_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  wr_index;
    logic [31:0] wr_data;
    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface
`default_nettype wire

[src/edge_clip_line_intersection_top.sv]
// Top level of the edge versus clip line intersection block.
// The block takes one polygon edge per clock cycle and returns one result per edge,
// in order. Between an input transfer and the matching output transfer lie two
// front-end stages that form the signed distances of both endpoints from the clip
// line (four signed 33x33 products, then the sums and their signs), the four-entry
// job queue, 34 divider stages and the output register. The divider handles x, y,
// u and v in four parallel lanes, each step stage folding in one bit of the
// coordinate delta, so every component is exact and rounded to nearest with halves
// away from zero. The queue lets the front end keep taking edges while the result
// side is held off; when the queue is full, input ready drops. Clip line points
// are written through the configuration channel (indexes 0 to 3, other indexes are
// ignored) and must only change while no edge is in flight; the configuration
// channel is always ready.
`default_nettype none
module edge_clip_line_intersection_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ecli_seg_if.sink    i_seg,
    ecli_cfg_if.sink    i_cfg,
    ecli_hit_if.source  o_hit
);
    // Clip line points P (start) and Q (end).
    logic signed [31:0] r_px, r_py, r_qx, r_qy;

    logic            push, full, q_valid, pop;
    ecli_pkg::t_job  push_job, q_job;

    // Register writes are taken directly into the clip registers, so the port never back-pressures.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_qx <= '0;
            r_qy <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.wr_index)
                ecli_pkg::REG_CLIP_START_X: r_px <= i_cfg.wr_data;
                ecli_pkg::REG_CLIP_START_Y: r_py <= i_cfg.wr_data;
                ecli_pkg::REG_CLIP_END_X:   r_qx <= i_cfg.wr_data;
                ecli_pkg::REG_CLIP_END_Y:   r_qy <= i_cfg.wr_data;
                default: begin
                end
            endcase
        end
    end

    // Front end: distances, crossing test and the numerator/denominator of t.
    ecli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (i_seg),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    // Queue that decouples front-end stalls from result-side stalls.
    ecli_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // Back end: interpolation by exact pipelined division and the result register.
    ecli_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (q_job),
        .o_pop   (pop),
        .o_hit   (o_hit)
    );
endmodule
`default_nettype wire

[src/ecli_front.sv]
// Front end: signed distances, sign classification and interpolation setup.
`default_nettype none
module ecli_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    ecli_seg_if.sink                  i_seg,
    input  wire logic signed [31:0]   i_px,
    input  wire logic signed [31:0]   i_py,
    input  wire logic signed [31:0]   i_qx,
    input  wire logic signed [31:0]   i_qy,
    input  wire logic                 i_full,
    output logic                      o_push,
    output ecli_pkg::t_job            o_job
);
    logic en;
    logic r1_v, r2_v;
    logic signed [ecli_pkg::PW-1:0] r1_pax, r1_pay, r1_pbx, r1_pby;
    logic [ecli_pkg::LANES-1:0][ecli_pkg::CW-1:0] r1_ca;
    logic [ecli_pkg::LANES-1:0][ecli_pkg::DW-1:0] r1_mag;
    logic [ecli_pkg::LANES-1:0]                   r1_dneg;
    ecli_pkg::t_job r2_job, n2_job;

    logic signed [ecli_pkg::DW-1:0] nx, ny, dax, day, dbx, dby;
    logic signed [ecli_pkg::CW-1:0] cas [ecli_pkg::LANES];
    logic signed [ecli_pkg::CW-1:0] cbs [ecli_pkg::LANES];
    logic signed [ecli_pkg::DW-1:0] dl  [ecli_pkg::LANES];
    logic [ecli_pkg::DW-1:0]        n1_mag [ecli_pkg::LANES];
    logic                           n1_dneg [ecli_pkg::LANES];

    assign en          = !i_full;
    assign i_seg.ready = en;

    always_comb begin
        nx  = i_py - i_qy;
        ny  = i_qx - i_px;
        dax = i_seg.seg_start_x - i_px;
        day = i_seg.seg_start_y - i_py;
        dbx = i_seg.seg_end_x - i_px;
        dby = i_seg.seg_end_y - i_py;
        cas[0] = i_seg.seg_start_x;  cbs[0] = i_seg.seg_end_x;
        cas[1] = i_seg.seg_start_y;  cbs[1] = i_seg.seg_end_y;
        cas[2] = i_seg.seg_start_u;  cbs[2] = i_seg.seg_end_u;
        cas[3] = i_seg.seg_start_v;  cbs[3] = i_seg.seg_end_v;
        for (int l = 0; l < ecli_pkg::LANES; l++) begin
            dl[l]      = cbs[l] - cas[l];
            n1_dneg[l] = dl[l][ecli_pkg::DW-1];
            n1_mag[l]  = n1_dneg[l] ? ecli_pkg::DW'(-dl[l]) : ecli_pkg::DW'(dl[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pax <= dax * nx;
            r1_pay <= day * ny;
            r1_pbx <= dbx * nx;
            r1_pby <= dby * ny;
            for (int l = 0; l < ecli_pkg::LANES; l++) begin
                r1_ca[l]   <= cas[l];
                r1_mag[l]  <= n1_mag[l];
                r1_dneg[l] <= n1_dneg[l];
            end
        end
    end

    always_comb begin
        logic signed [ecli_pkg::SW-1:0] sa, sb;
        logic signed [ecli_pkg::MW-1:0] sd;
        logic                           za, zb;
        sa = r1_pax + r1_pay;
        sb = r1_pbx + r1_pby;
        sd = sa - sb;
        za = (sa == '0);
        zb = (sb == '0);
        n2_job = '0;
        // Three-way signs differ when exactly one is zero or the signs oppose.
        n2_job.crosses     = (za != zb) || (!za && !zb && (sa[ecli_pkg::SW-1] != sb[ecli_pkg::SW-1]));
        n2_job.point_valid = n2_job.crosses && (sa[ecli_pkg::SW-1] || sb[ecli_pkg::SW-1]);
        n2_job.num  = sa[ecli_pkg::SW-1] ? ecli_pkg::MW'(-sa) : ecli_pkg::MW'(sa);
        n2_job.den  = sd[ecli_pkg::MW-1] ? ecli_pkg::MW'(-sd) : ecli_pkg::MW'(sd);
        n2_job.ca   = r1_ca;
        n2_job.mag  = r1_mag;
        n2_job.dneg = r1_dneg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_job <= n2_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_seg.valid;
            r2_v <= r1_v;
        end
    end

    assign o_push = r2_v && en;
    assign o_job  = r2_job;
endmodule
`default_nettype wire

[src/ecli_fifo.sv]
// Short queue of classified jobs between the front end and the divider.
`default_nettype none
module ecli_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ecli_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output ecli_pkg::t_job       o_job
);
    ecli_pkg::t_job r_mem [ecli_pkg::QDEPTH];
    logic [ecli_pkg::QPW-1:0] r_wp, r_rp;
    logic [ecli_pkg::QPW:0]   r_cnt;
    logic                     do_pop;

    assign o_full  = (r_cnt == (ecli_pkg::QPW+1)'(ecli_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (ecli_pkg::QPW+1)'(i_push) - (ecli_pkg::QPW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

[src/ecli_back.sv]
// Back end: pipelined product-division per lane, rounding and output register.
`default_nettype none
module ecli_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire ecli_pkg::t_job  i_job,
    output logic                 o_pop,
    ecli_hit_if.source           o_hit
);
    logic en;
    logic           r_v  [ecli_pkg::STEPS+1];
    ecli_pkg::t_div r_st [ecli_pkg::STEPS+1];
    logic           r_out_v;
    logic           r_crosses, r_pv;
    logic [ecli_pkg::LANES-1:0][ecli_pkg::CW-1:0] r_hit, n_hit;

    assign en    = !r_out_v || o_hit.ready;
    assign o_pop = en;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0].job <= i_job;
            r_st[0].rem <= '0;
            r_st[0].quo <= '0;
        end
    end

    for (genvar s = 0; s < ecli_pkg::STEPS; s++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[s+1] <= ecli_pkg::div_step(r_st[s], 6'(ecli_pkg::STEPS - 1 - s));
            end
        end
    end

    always_comb begin
        logic [ecli_pkg::QW-1:0] off;
        logic [ecli_pkg::QW-1:0] base;
        logic [ecli_pkg::QW-1:0] sum;
        for (int l = 0; l < ecli_pkg::LANES; l++) begin
            off  = r_st[ecli_pkg::STEPS].quo[l]
                 + ecli_pkg::QW'({r_st[ecli_pkg::STEPS].rem[l], 1'b0}
                                 >= {1'b0, r_st[ecli_pkg::STEPS].job.den});
            base = {{(ecli_pkg::QW-ecli_pkg::CW){r_st[ecli_pkg::STEPS].job.ca[l][ecli_pkg::CW-1]}},
                    r_st[ecli_pkg::STEPS].job.ca[l]};
            sum  = r_st[ecli_pkg::STEPS].job.dneg[l] ? base - off : base + off;
            n_hit[l] = r_st[ecli_pkg::STEPS].job.point_valid ? sum[ecli_pkg::CW-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit     <= n_hit;
            r_crosses <= r_st[ecli_pkg::STEPS].job.crosses;
            r_pv      <= r_st[ecli_pkg::STEPS].job.point_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= ecli_pkg::STEPS; s++) begin
                r_v[s] <= 1'b0;
            end
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
            for (int s = 0; s < ecli_pkg::STEPS; s++) begin
                r_v[s+1] <= r_v[s];
            end
            r_out_v <= r_v[ecli_pkg::STEPS];
        end
    end

    assign o_hit.valid       = r_out_v;
    assign o_hit.crosses     = r_crosses;
    assign o_hit.point_valid = r_pv;
    assign o_hit.hit_x       = r_hit[0];
    assign o_hit.hit_y       = r_hit[1];
    assign o_hit.hit_u       = r_hit[2];
    assign o_hit.hit_v       = r_hit[3];
endmodule
`default_nettype wire

[bench/ecli_tb_ifs_note.sv]
// Shared stimulus and expected-result types for the edge clip testbench.
package ecli_tb_pkg;
    typedef struct {
        logic signed [31:0] ax, ay, au, av, bx, by, bu, bv;
    } t_edge;

    typedef struct {
        logic               crosses;
        logic               point_valid;
        logic signed [31:0] x, y, u, v;
    } t_hit;
endpackage

[bench/tb_edge_clip_line_intersection_top.sv]
// Self-checking testbench for the edge versus clip line intersection block.
`default_nettype none
module tb_edge_clip_line_intersection_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ecli_pkg::*;
    import ecli_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    ecli_seg_if seg_if();
    ecli_cfg_if cfg_if();
    ecli_hit_if hit_if();

    edge_clip_line_intersection_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_if.sink),
        .i_cfg   (cfg_if.sink),
        .o_hit   (hit_if.source)
    );

    // Our copy of the clip line registers.
    logic signed [31:0] line_px, line_py, line_qx, line_qy;

    t_hit pending_hits[$];
    int   error_count = 0;
    int   edges_sent = 0;
    int   hits_seen = 0;
    int   points_seen = 0;
    int   rx_wait_max = 18;
    bit   run_done = 0;

    // Interpolate one component at t = num/den, rounded half away from zero.
    function automatic logic signed [31:0] lerp_component(logic signed [31:0] ca,
            logic signed [31:0] cb, logic [127:0] num, logic [127:0] den);
        logic signed [33:0] delta;
        logic [33:0]        dmag;
        logic [127:0]       quo;
        delta = 34'(cb) - 34'(ca);
        dmag = delta < 0 ? 34'(-delta) : 34'(delta);
        quo = ((num * 128'(dmag)) * 2 + den) / (den * 2);
        return delta < 0 ? 32'(34'(ca) - 34'(quo)) : 32'(34'(ca) + 34'(quo));
    endfunction

    // Side test and expected intersection of one edge against the current clip line.
    function automatic t_hit clip_edge(t_edge e);
        t_hit r;
        logic signed [33:0]  nx, ny;
        logic signed [127:0] sa, sb;
        logic [127:0]        num, den;
        int                  ga, gb;
        nx = 34'(line_py) - 34'(line_qy);
        ny = 34'(line_qx) - 34'(line_px);
        sa = 128'(34'(e.ax) - 34'(line_px)) * 128'(nx)
           + 128'(34'(e.ay) - 34'(line_py)) * 128'(ny);
        sb = 128'(34'(e.bx) - 34'(line_px)) * 128'(nx)
           + 128'(34'(e.by) - 34'(line_py)) * 128'(ny);
        ga = sa < 0 ? -1 : (sa != 0);
        gb = sb < 0 ? -1 : (sb != 0);
        r = '{default: '0};
        r.crosses = ga != gb;
        r.point_valid = r.crosses && (ga < 0 || gb < 0);
        if (r.point_valid) begin
            num = sa < 0 ? -sa : sa;
            den = (sa - sb) < 0 ? -(sa - sb) : (sa - sb);
            r.x = lerp_component(e.ax, e.bx, num, den);
            r.y = lerp_component(e.ay, e.by, num, den);
            r.u = lerp_component(e.au, e.bu, num, den);
            r.v = lerp_component(e.av, e.bv, num, den);
        end
        return r;
    endfunction

    // Write one clip register; the model ignores unknown indexes just as the block does.
    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        cfg_if.valid    <= 1'b1;
        cfg_if.wr_index <= idx;
        cfg_if.wr_data  <= data;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_CLIP_START_X: line_px = data;
            REG_CLIP_START_Y: line_py = data;
            REG_CLIP_END_X:   line_qx = data;
            REG_CLIP_END_Y:   line_qy = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Wait until all results are back, then let the pipeline drain a bit more.
    task automatic drain();
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_line(logic [31:0] px, logic [31:0] py, logic [31:0] qx,
            logic [31:0] qy);
        drain();
        write_reg(REG_CLIP_START_X, px);
        write_reg(REG_CLIP_START_Y, py);
        write_reg(REG_CLIP_END_X, qx);
        write_reg(REG_CLIP_END_Y, qy);
    endtask

    // Offer one edge, optionally after a random gap, and queue its expected result.
    task automatic send_edge(t_edge e, bit may_idle);
        int gap;
        gap = may_idle ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_if.valid       <= 1'b1;
        seg_if.seg_start_x <= e.ax;
        seg_if.seg_start_y <= e.ay;
        seg_if.seg_start_u <= e.au;
        seg_if.seg_start_v <= e.av;
        seg_if.seg_end_x   <= e.bx;
        seg_if.seg_end_y   <= e.by;
        seg_if.seg_end_u   <= e.bu;
        seg_if.seg_end_v   <= e.bv;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
        pending_hits.push_back(clip_edge(e));
        edges_sent++;
    endtask

    task automatic idle_input();
        seg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random coordinate: mostly small values so crossings are common,
    // sometimes full-range so every bit toggles.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 2 * 640)) - 640) <<< 16
                            | 32'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_edge rand_edge();
        t_edge e;
        e.ax = rand_coord(); e.ay = rand_coord();
        e.au = $urandom();   e.av = $urandom();
        e.bx = rand_coord(); e.by = rand_coord();
        e.bu = $urandom();   e.bv = $urandom();
        return e;
    endfunction

    // Directed edges against a horizontal line y = 0 with the normal pointing to +y
    // (P = (0,0), Q = (0x10000,0)), then the extremes and a degenerate line.
    task automatic test_directed();
        t_edge e;
        set_line(32'h0, 32'h0, 32'h1_0000, 32'h0);
        // Negative start, positive end: point with interpolated u, v.
        e = '{32'h1_0000, -32'sh2_0000, 32'h0, 32'h10_0000,
              32'h3_0000, 32'h2_0000, 32'h7FFF_FFFF, -32'sh10_0000};
        send_edge(e, 0);
        // Positive start, negative end.
        e = '{32'h0, 32'h5_0000, 32'h8000_0000, 32'h1,
              32'h0, -32'sh1_0000, 32'h7FFF_FFFF, 32'h0};
        send_edge(e, 0);
        // Both positive, both negative: no crossing.
        e = '{32'h0, 32'h1, 32'h1, 32'h1, 32'h5, 32'h7FFF_FFFF, 32'h2, 32'h2};
        send_edge(e, 0);
        e = '{32'h0, -32'sh1, 32'h1, 32'h1, 32'h5, 32'h8000_0000, 32'h2, 32'h2};
        send_edge(e, 0);
        // Touching: one end on the line, other positive gives a crossing but no point.
        e = '{32'h4_0000, 32'h0, 32'h9, 32'h9, 32'h4_0000, 32'h3_0000, 32'h8, 32'h8};
        send_edge(e, 0);
        // Touching with the other end negative gives the touching end as point.
        e = '{32'h4_0000, -32'sh3_0000, 32'h9, 32'h9, 32'h4_0000, 32'h0, 32'h8, 32'h8};
        send_edge(e, 0);
        // Both ends on the line.
        e = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0};
        send_edge(e, 0);
        // Rounding halfway case: t = 1/2 on odd deltas.
        e = '{32'h0, -32'sh1, 32'h0, 32'h1, 32'h1, 32'h1, -32'sh1, 32'h0};
        send_edge(e, 0);
        // Full-range extremes across the line.
        e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        send_edge(e, 0);
        e = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
              32'h8000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        send_edge(e, 0);
        idle_input();
        // Extreme clip line: corners of the coordinate range.
        set_line(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 0; i < 6; i++) send_edge(rand_edge(), 0);
        e = '{32'h8000_0000, 32'h8000_0000, 32'h1, 32'h2,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h3, 32'h4};
        send_edge(e, 0);
        idle_input();
        // Degenerate line with P equal to Q, plus a write to an unknown index.
        set_line(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
        write_reg(8'hFF, 32'hDEAD_BEEF);
        write_reg(8'd4, 32'h1);
        for (int i = 0; i < 4; i++) send_edge(rand_edge(), 0);
        idle_input();
    endtask

    // Random edges in phases, each with a fresh clip line.
    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 7)
                set_line(32'h0, 32'h0, 32'h0, 32'h0);  // back to the reset line
            else
                set_line(rand_coord(), rand_coord(), rand_coord(), rand_coord());
            for (int i = 0; i < 100; i++) begin
                // Some phases run back to back with no gaps.
                send_edge(rand_edge(), phase % 3 != 0);
                if (i == 50 && phase == 2) begin
                    // Hold off until every outstanding result is back.
                    seg_if.valid <= 1'b0;
                    while (pending_hits.size() != 0) @(posedge i_clk);
                end
            end
            idle_input();
        end
    endtask

    // Result side: random stalls, compare each transfer with the oldest expectation.
    initial begin
        t_hit exp_hit;
        int   stall;
        hit_if.ready = 1'b0;
        @(posedge i_clk);
        while (!run_done) begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, rx_wait_max);
            if (stall != 0) begin
                hit_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            hit_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!hit_if.valid && !run_done) @(posedge i_clk);
            if (hit_if.valid) begin
                if (pending_hits.size() == 0) begin
                    $error("result transfer with no edge outstanding");
                    error_count++;
                end else begin
                    exp_hit = pending_hits.pop_front();
                    hits_seen++;
                    if (exp_hit.point_valid) points_seen++;
                    if (hit_if.crosses !== exp_hit.crosses) begin
                        $error("crosses: expected %0d actual %0d",
                               exp_hit.crosses, hit_if.crosses);
                        error_count++;
                    end
                    if (hit_if.point_valid !== exp_hit.point_valid) begin
                        $error("point_valid: expected %0d actual %0d",
                               exp_hit.point_valid, hit_if.point_valid);
                        error_count++;
                    end
                    if (hit_if.hit_x !== exp_hit.x) begin
                        $error("hit_x: expected %h actual %h", exp_hit.x, hit_if.hit_x);
                        error_count++;
                    end
                    if (hit_if.hit_y !== exp_hit.y) begin
                        $error("hit_y: expected %h actual %h", exp_hit.y, hit_if.hit_y);
                        error_count++;
                    end
                    if (hit_if.hit_u !== exp_hit.u) begin
                        $error("hit_u: expected %h actual %h", exp_hit.u, hit_if.hit_u);
                        error_count++;
                    end
                    if (hit_if.hit_v !== exp_hit.v) begin
                        $error("hit_v: expected %h actual %h", exp_hit.v, hit_if.hit_v);
                        error_count++;
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed cases, random phases, then drain and report.
    initial begin
        seg_if.valid = 1'b0;
        {seg_if.seg_start_x, seg_if.seg_start_y, seg_if.seg_start_u,
         seg_if.seg_start_v} = '0;
        {seg_if.seg_end_x, seg_if.seg_end_y, seg_if.seg_end_u, seg_if.seg_end_v} = '0;
        cfg_if.valid = 1'b0;
        cfg_if.wr_index = '0;
        cfg_if.wr_data = '0;
        line_px = 0; line_py = 0; line_qx = 0; line_qy = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        seg_if.valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        run_done = 1;
        @(posedge i_clk);
        if (pending_hits.size() != 0) begin
            $error("%0d results never arrived", pending_hits.size());
            error_count++;
        end
        $display("Sent %0d edges over 11 clip lines; checked %0d results, %0d with a point.",
                 edges_sent, hits_seen, points_seen);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: fails the run if the main sequence has not finished first.
    initial begin
        #400us;
        $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
